// ----- hdl/swm_pkg.sv -----
// Shared constants and types for the sliding window maximum filter.
package swm_pkg;

    // Sample and window geometry.
    localparam int SAMPLE_W   = 32;
    localparam int WINDOW_MAX = 32;
    localparam int SIZE_W     = 6;
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
    localparam int LEVELS     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int TREE_N     = 1 << LEVELS;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Most negative sample; it never wins a compare against a real sample.
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

// ----- hdl/swm_cell.sv -----
// One window cell: holds a sample, passes it on, and offers it to the max tree.
module swm_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  swm_pkg::t_sample  i_prev,
    input  logic              i_in_window,
    output swm_pkg::t_sample  o_data,
    output swm_pkg::t_sample  o_cand
);

    swm_pkg::t_sample r_data;
    swm_pkg::t_sample n_data;

    // The cell takes its neighbor's sample whenever a request is accepted.
    always_comb begin
        n_data = i_shift ? i_prev : r_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The candidate is the value after the shift, or the floor when out of the window.
    assign o_cand = i_in_window ? n_data : swm_pkg::SAMPLE_MIN;
    assign o_data = r_data;

endmodule

// ----- hdl/swm_max2.sv -----
// Registered signed maximum of two samples, one node of the comparator tree.
module swm_max2 (
    input  logic              i_clk,
    input  logic              i_en,
    input  swm_pkg::t_sample  i_a,
    input  swm_pkg::t_sample  i_b,
    output swm_pkg::t_sample  o_max
);

    swm_pkg::t_sample r_max;
    swm_pkg::t_sample n_max;

    // Pick the larger value; it loads only when the stage advances.
    always_comb begin
        n_max = (i_b > i_a) ? i_b : i_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max <= n_max;
        end
    end

    assign o_max = r_max;

endmodule

// ----- hdl/sliding_window_maximum.sv -----
// Sliding window maximum filter: a shifting row of cells feeding a registered max tree.
// Each accepted request reaches its result through the registered levels of the max tree.
// Throughput: one sample per cycle if not stalled; a result leaves each cycle it is taken.
// The log2 depth of the pairwise comparator tree sets the latency.
// Reset clears the fill count, the tree valid bits, and sets window_size to 1.
// Window cells are not cleared; only windows of the current sequence give valid results.
module sliding_window_maximum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_sample,
    input  logic                          i_first,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_window_max,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swm_pkg::SIZE_W-1:0]    i_cfg_data
);

    logic [swm_pkg::SIZE_W-1:0] r_window_size;
    logic [swm_pkg::FILL_W-1:0] r_fill;
    logic [swm_pkg::FILL_W-1:0] n_fill;
    logic [swm_pkg::FILL_W-1:0] w_fill_base;
    logic [swm_pkg::SIZE_W-1:0] w_k;
    logic                       w_accept;
    logic                       w_take;

    logic [swm_pkg::LEVELS:1]   r_vld;
    logic [swm_pkg::LEVELS:1]   w_en;

    swm_pkg::t_sample w_data [0:swm_pkg::WINDOW_MAX-1];
    swm_pkg::t_sample w_lvl  [0:swm_pkg::LEVELS][0:swm_pkg::TREE_N-1];

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::SIZE_W'(1);
        end else if (i_cfg_valid) begin
            r_window_size <= i_cfg_data;
        end
    end

    // Effective window: zero acts as one, and it saturates at the cell count.
    always_comb begin
        if (r_window_size == '0) begin
            w_k = swm_pkg::SIZE_W'(1);
        end else if (32'(r_window_size) > swm_pkg::WINDOW_MAX) begin
            w_k = swm_pkg::SIZE_W'(swm_pkg::WINDOW_MAX);
        end else begin
            w_k = r_window_size;
        end
    end

    // Stage enables: a stage loads when it is empty or its successor loads.
    always_comb begin
        w_en[swm_pkg::LEVELS] = !r_vld[swm_pkg::LEVELS] || i_out_ready;
        for (int l = swm_pkg::LEVELS - 1; l >= 1; l--) begin
            w_en[l] = !r_vld[l] || w_en[l+1];
        end
    end

    assign o_in_ready = w_en[1];
    assign w_accept   = i_in_valid && o_in_ready;

    // Fill count of the current sequence, restarted by the first flag.
    always_comb begin
        w_fill_base = i_first ? '0 : r_fill;
        if (32'(w_fill_base) < swm_pkg::WINDOW_MAX) begin
            n_fill = w_fill_base + swm_pkg::FILL_W'(1);
        end else begin
            n_fill = w_fill_base;
        end
        w_take = w_accept && (32'(n_fill) >= 32'(w_k));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    // Row of cells, newest sample in cell zero.
    for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
        swm_pkg::t_sample w_prev;
        if (i == 0) begin : g_head
            assign w_prev = i_sample;
        end else begin : g_body
            assign w_prev = w_data[i-1];
        end
        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_accept),
            .i_prev      (w_prev),
            .i_in_window (32'(i) < 32'(w_k)),
            .o_data      (w_data[i]),
            .o_cand      (w_lvl[0][i])
        );
    end

    // Pad the tree leaves past the last cell with the floor value.
    for (genvar j = swm_pkg::WINDOW_MAX; j < swm_pkg::TREE_N; j++) begin : g_pad
        assign w_lvl[0][j] = swm_pkg::SAMPLE_MIN;
    end

    // Registered comparator tree, one level per cycle when that level's enable is high.
    for (genvar l = 1; l <= swm_pkg::LEVELS; l++) begin : g_lvl
        for (genvar j = 0; j < swm_pkg::TREE_N; j++) begin : g_node
            if (j < (swm_pkg::TREE_N >> l)) begin : g_used
                swm_max2 u_max2 (
                    .i_clk (i_clk),
                    .i_en  (w_en[l]),
                    .i_a   (w_lvl[l-1][2*j]),
                    .i_b   (w_lvl[l-1][2*j+1]),
                    .o_max (w_lvl[l][j])
                );
            end else begin : g_unused
                assign w_lvl[l][j] = swm_pkg::SAMPLE_MIN;
            end
        end
    end

    // Valid bits follow the tree; an item without a result leaves a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_take;
            end
            for (int l = 2; l <= swm_pkg::LEVELS; l++) begin
                if (w_en[l]) begin
                    r_vld[l] <= r_vld[l-1];
                end
            end
        end
    end

    assign o_out_valid  = r_vld[swm_pkg::LEVELS];
    assign o_window_max = w_lvl[swm_pkg::LEVELS][0];

    // The input side never stalls while the result register is empty.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // The fill count saturates at the cell count.
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= swm_pkg::WINDOW_MAX)
        else $error("fill count beyond the cell count");

    // A request flagged first restarts the sequence at one sample.
    a_first_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_first) |=> (r_fill == swm_pkg::FILL_W'(1)))
        else $error("first flag did not restart the fill count");

    // A result only enters the tree when the window is full.
    a_take_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (32'(n_fill) >= 32'(w_k)) && w_accept)
        else $error("result produced before the window filled");

endmodule

// ----- sim/tb_sliding_window_maximum.sv -----
// Self-checking testbench for the sliding window maximum filter.
module tb_sliding_window_maximum;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles of quiet after the last result before the block counts as idle.
    localparam int DRAIN_CYCLES = swm_pkg::LEVELS + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 56;

    typedef logic [swm_pkg::SIZE_W-1:0] t_size;

    typedef struct {
        swm_pkg::t_sample sample;
        logic             first;
    } t_sample_req;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_NARROW,
        STYLE_FALLING,
        STYLE_RISING
    } t_sample_style;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_LONG_STALL
    } t_ready_mode;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    swm_pkg::t_sample    i_sample     = '0;
    logic                i_first      = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    swm_pkg::t_sample    o_window_max;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    t_size               i_cfg_data   = '0;

    sliding_window_maximum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_first      (i_first),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_window_max (o_window_max),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Requests waiting to be driven, and window maxima waiting to come out.
    t_sample_req      pending_reqs[$];
    swm_pkg::t_sample expected_max[$];
    int               mismatch_count = 0;

    // Shadow copy of the filter state, newest sample in cell 0.
    swm_pkg::t_sample shadow_cells[swm_pkg::WINDOW_MAX];
    int               shadow_fill = 0;
    t_size            shadow_size = t_size'(1);

    // Advance the shadow window by one sample and queue the maximum it yields, if any.
    function automatic void predict_window_max(swm_pkg::t_sample s, logic first);
        int               span;
        swm_pkg::t_sample best;
        if (first) shadow_fill = 0;
        for (int i = swm_pkg::WINDOW_MAX - 1; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[0] = s;
        if (shadow_fill < swm_pkg::WINDOW_MAX) shadow_fill++;
        // A size of zero acts as one; sizes past the cell count saturate.
        span = int'(shadow_size);
        if (span == 0) span = 1;
        if (span > swm_pkg::WINDOW_MAX) span = swm_pkg::WINDOW_MAX;
        if (shadow_fill >= span) begin
            best = shadow_cells[0];
            for (int i = 1; i < span; i++) begin
                if (shadow_cells[i] > best) best = shadow_cells[i];
            end
            expected_max.push_back(best);
        end
    endfunction

    // Sample driver: bursts of random length separated by random gaps, some of them empty.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_sample_req next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_window_max(i_sample, i_first);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample   <= next_req.sample;
                    i_first    <= next_req.first;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own back-pressure pattern.
    int          pattern_cnt = 0;
    t_ready_mode ready_mode  = READY_ALWAYS;

    always @(posedge i_clk) begin
        swm_pkg::t_sample want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_max.size() == 0) begin
                    $display("%0t: window_max expected none, got %0d", $time, o_window_max);
                    mismatch_count++;
                end else begin
                    want = expected_max.pop_front();
                    if (o_window_max !== want) begin
                        $display("%0t: window_max expected %0d, got %0d",
                                 $time, want, o_window_max);
                        mismatch_count++;
                    end
                end
            end
            pattern_cnt++;
            if (pattern_cnt % 96 == 0) ready_mode = t_ready_mode'($urandom_range(0, 3));
            case (ready_mode)
                READY_ALWAYS: i_out_ready <= 1'b1;
                READY_MOSTLY: i_out_ready <= ($urandom_range(0, 9) < 7);
                READY_RARELY: i_out_ready <= ($urandom_range(0, 9) < 3);
                default:      i_out_ready <= (pattern_cnt % 16 >= 6);
            endcase
        end
    end

    // Watchdog on the whole run.
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic swm_pkg::t_sample pick_sample(t_sample_style style, int idx, int base);
        case (style)
            STYLE_RANDOM:  return swm_pkg::t_sample'($urandom);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       return swm_pkg::SAMPLE_MIN;
                    1:       return swm_pkg::SAMPLE_MIN + 1;
                    2:       return 32'sh7FFF_FFFF;
                    3:       return 32'sh7FFF_FFFE;
                    4:       return 0;
                    default: return -1;
                endcase
            end
            STYLE_NARROW:  return swm_pkg::t_sample'(int'($urandom_range(0, 15)) - 8);
            STYLE_FALLING: return swm_pkg::t_sample'(base - idx * 3);
            default:       return swm_pkg::t_sample'(base + idx);
        endcase
    endfunction

    task automatic push_req(swm_pkg::t_sample s, logic first);
        t_sample_req r;
        r.sample = s;
        r.first  = first;
        pending_reqs.push_back(r);
    endtask

    // Wait for every request to go in and every maximum to come out, then stay quiet.
    task automatic wait_drain();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge i_clk);
            if (pending_reqs.size() == 0 && !i_in_valid && expected_max.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_window_size(t_size value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_size = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_size size_for_phase(int p);
        case (p)
            0:       return t_size'(32);
            1:       return t_size'(33);
            2:       return t_size'(63);
            3:       return t_size'(0);
            4:       return t_size'(1);
            5:       return t_size'(2);
            6:       return t_size'(31);
            7:       return t_size'(5);
            default: return t_size'($urandom_range(0, 63));
        endcase
    endfunction

    initial begin
        int            span;
        int            len;
        int            base;
        int            queued;
        logic          first_flag;
        t_sample_style style;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window size of one, first flag or not: every sample is its own maximum.
        push_req(32'sh7FFF_FFFF, 1'b0);
        push_req(swm_pkg::SAMPLE_MIN, 1'b0);
        push_req(0, 1'b0);
        push_req(-1, 1'b0);
        push_req(1, 1'b1);
        wait_drain();

        // A sequence shorter than the window yields nothing.
        write_window_size(t_size'(3));
        push_req(5, 1'b1);
        push_req(10, 1'b0);
        wait_drain();

        // Shrinking the window mid-sequence takes effect on the next sample.
        write_window_size(t_size'(2));
        push_req(-3, 1'b0);
        push_req(swm_pkg::SAMPLE_MIN, 1'b1);
        push_req(swm_pkg::SAMPLE_MIN, 1'b0);
        wait_drain();

        // A window size of zero behaves as one.
        write_window_size(t_size'(0));
        push_req(32'sh7FFF_FFFF, 1'b0);
        push_req(-7, 1'b1);
        wait_drain();

        // Random phases: mostly well-formed sequences around the window length.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_window_size(size_for_phase(p));
            span = int'(shadow_size);
            if (span == 0) span = 1;
            if (span > swm_pkg::WINDOW_MAX) span = swm_pkg::WINDOW_MAX;
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, span);
                else
                    len = span + $urandom_range(0, 40);
                style      = t_sample_style'($urandom_range(0, 4));
                base       = int'($urandom_range(0, 2000000)) - 1000000;
                first_flag = ($urandom_range(0, 7) != 0);
                for (int i = 0; i < len; i++) begin
                    push_req(pick_sample(style, i, base), (i == 0) ? first_flag : 1'b0);
                end
                queued += len;
            end
            wait_drain();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
